>>> hdl/mem_pkg.sv
// Shared types, constants and lookup functions of the mesh element measure block.
package mem_pkg;

    localparam int STORED_NODES      = 8;
    localparam int MAX_ELEMENT_NODES = 20;
    localparam int COORD_W           = 32;
    localparam int IDX_W             = $clog2(STORED_NODES);
    localparam int ADDR_W            = IDX_W + 1;
    localparam int CNT_W             = $clog2(MAX_ELEMENT_NODES + 1);

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int MEAS_W   = 64;

    // datapath widths
    localparam int DIFF_W = COORD_W + 1;       // coordinate difference
    localparam int CRS_W  = 2 * DIFF_W;        // cross product component
    localparam int PROD_W = 2 * CRS_W;         // unsigned product magnitude
    localparam int ACC_W  = PROD_W + 2;        // dot product accumulator
    localparam int ROOT_W = CRS_W;             // square root of a PROD_W value
    localparam int REM_W  = ROOT_W + 2;
    localparam int AREA_W = ROOT_W + 1;
    localparam int VOL_W  = 3 * DIFF_W + 4;    // six triple products
    localparam int AREA_SHIFT = 9;
    localparam int VOL_SHIFT  = 25;            // 24 fraction bits, then halve
    // divide by three one 16-bit digit at a time; dividend padded to whole digits
    localparam int DIG_W  = 16;
    localparam int QUO_W  = ((VOL_W - VOL_SHIFT + DIG_W - 1) / DIG_W) * DIG_W;
    localparam int DIV3_SHIFT = 19;
    localparam logic [DIG_W+1:0] DIV3_MUL = 18'd174763;   // ceil(2^19 / 3)
    localparam int ITER_W = 7;

    localparam logic [ITER_W-1:0] MUL_LAST  = ITER_W'(CRS_W - 1);
    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(ROOT_W - 1);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(QUO_W / DIG_W - 1);

    localparam logic [KIND_W-1:0] KIND_TRI  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUAD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TET  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEX  = 3'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNSUP   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT     = 3'd4;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [IDX_W-1:0]   nidx_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } node_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [STATUS_W-1:0]     status;
        logic [STORED_NODES-1:0] present;
        logic                    bank;
    } job_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    // one piece of work: a tetrahedron or a cross product magnitude
    typedef struct packed {
        logic  tet;
        nidx_t n0;
        nidx_t n1;
        nidx_t n2;
        nidx_t n3;
    } part_t;

    function automatic part_t mk_part(input logic tet, input nidx_t a, input nidx_t b,
                                      input nidx_t c, input nidx_t d);
        part_t p;
        p.tet = tet;
        p.n0  = a;
        p.n1  = b;
        p.n2  = c;
        p.n3  = d;
        return p;
    endfunction

    function automatic part_t part_of(input logic [KIND_W-1:0] kind, input logic [2:0] num);
        part_t p;
        p = mk_part(1'b0, 3'd1, 3'd0, 3'd2, 3'd0);
        unique case (kind)
            KIND_TRI:  p = mk_part(1'b0, 3'd1, 3'd0, 3'd2, 3'd0);
            KIND_QUAD: p = (num == 3'd0) ? mk_part(1'b0, 3'd1, 3'd0, 3'd3, 3'd0)
                                         : mk_part(1'b0, 3'd2, 3'd1, 3'd2, 3'd3);
            KIND_TET:  p = mk_part(1'b1, 3'd0, 3'd1, 3'd2, 3'd3);
            default:
            begin
                unique case (num)
                    3'd0:    p = mk_part(1'b1, 3'd0, 3'd1, 3'd3, 3'd4);
                    3'd1:    p = mk_part(1'b1, 3'd1, 3'd2, 3'd3, 3'd6);
                    3'd2:    p = mk_part(1'b1, 3'd1, 3'd3, 3'd4, 3'd6);
                    3'd3:    p = mk_part(1'b1, 3'd3, 3'd4, 3'd6, 3'd7);
                    3'd4:    p = mk_part(1'b1, 3'd1, 3'd4, 3'd5, 3'd6);
                    default: p = mk_part(1'b1, 3'd4, 3'd6, 3'd7, 3'd5);
                endcase
            end
        endcase
        return p;
    endfunction

    function automatic logic [2:0] part_total(input logic [KIND_W-1:0] kind);
        logic [2:0] n;
        unique case (kind)
            KIND_QUAD: n = 3'd2;
            KIND_HEX:  n = 3'd6;
            default:   n = 3'd1;
        endcase
        return n;
    endfunction

    // operand indices of the six cross product terms
    function automatic logic [1:0] mul_a_idx(input logic [2:0] step);
        logic [1:0] i;
        unique case (step)
            3'd0, 3'd5: i = 2'd1;
            3'd1, 3'd2: i = 2'd2;
            default:    i = 2'd0;
        endcase
        return i;
    endfunction

    function automatic logic [1:0] mul_b_idx(input logic [2:0] step);
        logic [1:0] i;
        unique case (step)
            3'd0, 3'd3: i = 2'd2;
            3'd1, 3'd4: i = 2'd1;
            default:    i = 2'd0;
        endcase
        return i;
    endfunction

endpackage

>>> hdl/mesh_element_measure.sv
// Top level of the mesh element measure block: front end, job queue and back end.
//
// Nodes of an element arrive one beat at a time on the input channel
// (in_valid/in_ready); last_node closes the element. The first eight nodes
// are stored in one of two coordinate banks, so the next element can be
// taken in while the previous one is being worked on.
// One result beat (measure, status) leaves on the output channel
// (out_valid/out_ready) for each closed element, in order.
// Input: one node beat per cycle while a free bank exists.
// Every part (cross product magnitude or tetrahedron) costs nine products
// (66 shift-add steps each, plus setup and accumulate) on the one shared
// bit-serial multiplier, plus a square root for areas and a divide by three
// for volumes. Error results skip this work and go straight to the output.
// Reset clears the node counter, queue and sequencer; no element is open.
// A stalled receiver holds the result in the output register; the back end
// waits there, and the front end keeps taking nodes until both banks are busy.
module mesh_element_measure (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mem_pkg::KIND_W-1:0]   element_kind,
    input  logic                         node_present,
    input  logic [mem_pkg::COORD_W-1:0]  coord_x,
    input  logic [mem_pkg::COORD_W-1:0]  coord_y,
    input  logic [mem_pkg::COORD_W-1:0]  coord_z,
    input  logic                         last_node,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mem_pkg::MEAS_W-1:0]   measure,
    output logic [mem_pkg::STATUS_W-1:0] status
);
    import mem_pkg::*;

    // job hand-off between the two halves
    logic              push;
    job_t              push_job;
    logic              q_valid;
    job_t              q_job;
    logic              pop;
    // bank release and node read path
    rel_t              rel;
    logic [ADDR_W-1:0] rd_addr;
    node_t             rd_data;

    mem_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .element_kind (element_kind),
        .node_present (node_present),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .last_node    (last_node),
        .push         (push),
        .push_job     (push_job),
        .rel          (rel),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    mem_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    mem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rel       (rel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .measure   (measure),
        .status    (status)
    );

endmodule

>>> hdl/mem_front.sv
// Front end: takes node beats, stores coordinates in two banks and classifies elements.
module mem_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mem_pkg::KIND_W-1:0]  element_kind,
    input  logic                        node_present,
    input  logic [mem_pkg::COORD_W-1:0] coord_x,
    input  logic [mem_pkg::COORD_W-1:0] coord_y,
    input  logic [mem_pkg::COORD_W-1:0] coord_z,
    input  logic                        last_node,
    output logic                        push,
    output mem_pkg::job_t               push_job,
    input  mem_pkg::rel_t               rel,
    input  logic [mem_pkg::ADDR_W-1:0]  rd_addr,
    output mem_pkg::node_t              rd_data
);
    import mem_pkg::*;

    node_t                   node_mem [2*STORED_NODES];
    node_t                   rd_data_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [STORED_NODES-1:0] present_reg, present_next;
    logic                    wr_bank_reg, wr_bank_next;
    logic [1:0]              busy_reg, busy_next;

    logic                    accept;
    logic                    store_en;
    logic [KIND_W-1:0]       kind_eff;
    logic [STORED_NODES-1:0] pres_new;
    logic [STORED_NODES-1:0] need_mask;
    logic [CNT_W-1:0]        cnt_inc;
    logic [CNT_W-1:0]        need;
    logic [STATUS_W-1:0]     st;
    logic [ADDR_W-1:0]       wr_addr;
    node_t                   wr_node;

    assign in_ready = !busy_reg[wr_bank_reg];
    assign accept   = in_valid && in_ready;
    assign store_en = accept && (count_reg < CNT_W'(STORED_NODES));
    assign wr_addr  = {wr_bank_reg, count_reg[IDX_W-1:0]};
    assign rd_data  = rd_data_reg;

    always_comb
    begin
        wr_node.x = coord_x;
        wr_node.y = coord_y;
        wr_node.z = coord_z;
        kind_eff  = (count_reg == '0) ? element_kind : kind_reg;
        pres_new  = present_reg;
        if (store_en && node_present)
        begin
            pres_new = present_reg | (STORED_NODES'(1) << count_reg[IDX_W-1:0]);
        end
        cnt_inc = (count_reg < CNT_W'(MAX_ELEMENT_NODES)) ? count_reg + 1'b1 : count_reg;

        unique case (kind_eff)
            KIND_TRI:
            begin
                need      = CNT_W'(3);
                need_mask = STORED_NODES'(8'h07);
            end
            KIND_HEX:
            begin
                need      = CNT_W'(8);
                need_mask = STORED_NODES'(8'hff);
            end
            default:
            begin
                need      = CNT_W'(4);
                need_mask = STORED_NODES'(8'h0f);
            end
        endcase

        priority if (kind_eff > KIND_HEX)
            st = ST_UNSUP;
        else if (cnt_inc < need)
            st = ST_FEW;
        else if (kind_eff != KIND_HEX && (pres_new & need_mask) != need_mask)
            st = ST_MISSING;
        else
            st = ST_OK;

        push             = accept && last_node;
        push_job.kind    = kind_eff;
        push_job.status  = st;
        push_job.present = pres_new;
        push_job.bank    = wr_bank_reg;

        count_next   = count_reg;
        kind_next    = kind_reg;
        present_next = present_reg;
        wr_bank_next = wr_bank_reg;
        busy_next    = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (last_node)
            begin
                // element closed: hand the bank to the back end
                count_next             = '0;
                kind_next              = '0;
                present_next           = '0;
                wr_bank_next           = !wr_bank_reg;
                busy_next[wr_bank_reg] = 1'b1;
            end
            else
            begin
                count_next   = cnt_inc;
                kind_next    = kind_eff;
                present_next = pres_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            node_mem[wr_addr] <= wr_node;
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            kind_reg    <= '0;
            present_reg <= '0;
            wr_bank_reg <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            kind_reg    <= kind_next;
            present_reg <= present_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
        end
    end

    a_rel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid |-> busy_reg[rel.bank])
        else $error("bank released that was not in use");

endmodule

>>> hdl/mem_queue.sv
// Two-entry job queue between the front end and the back end.
module mem_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mem_pkg::job_t push_job,
    input  logic          pop,
    output logic          q_valid,
    output mem_pkg::job_t q_job
);
    import mem_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       q_full;

    assign q_valid = (fill_reg != 2'd0);
    assign q_full  = (fill_reg == 2'd2);
    assign q_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("job queue underflow");

endmodule

>>> hdl/mem_back.sv
// Back end: sequencer with a bit-serial multiplier, square root and divide by three.
module mem_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  mem_pkg::job_t                q_job,
    output logic                         pop,
    output logic [mem_pkg::ADDR_W-1:0]   rd_addr,
    input  mem_pkg::node_t               rd_data,
    output mem_pkg::rel_t                rel,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mem_pkg::MEAS_W-1:0]   measure,
    output logic [mem_pkg::STATUS_W-1:0] status
);
    import mem_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SEL     = 4'd1;
    localparam logic [3:0] S_LOAD    = 4'd2;
    localparam logic [3:0] S_DIFF    = 4'd3;
    localparam logic [3:0] S_MSTART  = 4'd4;
    localparam logic [3:0] S_MRUN    = 4'd5;
    localparam logic [3:0] S_MACC    = 4'd6;
    localparam logic [3:0] S_POST    = 4'd7;
    localparam logic [3:0] S_SQRT    = 4'd8;
    localparam logic [3:0] S_AREA    = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;
    localparam logic [3:0] S_DIV     = 4'd11;
    localparam logic [3:0] S_DIVDONE = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    logic [3:0]          state_reg, state_next;
    job_t                job_reg, job_next;
    logic [2:0]          part_reg, part_next;
    logic [2:0]          ld_cnt_reg, ld_cnt_next;
    node_t               lnode_reg [4];
    node_t               lnode_next [4];
    logic [DIFF_W-1:0]   x_reg [3];
    logic [DIFF_W-1:0]   x_next [3];
    logic [DIFF_W-1:0]   y_reg [3];
    logic [DIFF_W-1:0]   y_next [3];
    logic [DIFF_W-1:0]   u_reg [3];
    logic [DIFF_W-1:0]   u_next [3];
    logic [CRS_W-1:0]    c_reg [3];
    logic [CRS_W-1:0]    c_next [3];
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [3:0]          step_reg, step_next;
    logic [CRS_W-1:0]    a_mag_reg, a_mag_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                neg_reg, neg_next;
    logic [ITER_W-1:0]   it_reg, it_next;
    logic [PROD_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [AREA_W-1:0]   area_reg, area_next;
    logic [VOL_W-1:0]    vol_reg, vol_next;
    logic [QUO_W-1:0]    div_reg, div_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [1:0]          drem_reg, drem_next;
    logic [MEAS_W-1:0]   res_meas_reg, res_meas_next;
    logic [STATUS_W-1:0] res_stat_reg, res_stat_next;
    logic                out_valid_reg, out_valid_next;
    logic [MEAS_W-1:0]   measure_reg, measure_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    part_t               cur;
    logic [STORED_NODES-1:0] part_mask;
    nidx_t               ld_idx;
    logic [1:0]          dot_k;
    logic [CRS_W-1:0]    a_op, b_op;
    logic [CRS_W:0]      mul_sum;
    logic [ACC_W-1:0]    sprod;
    logic [ACC_W-1:0]    acc_abs;
    logic [REM_W+1:0]    sq_t, sq_trial;
    logic [DIG_W+1:0]    dv_t;
    logic [2*DIG_W+3:0]  dv_prod;
    logic [DIG_W-1:0]    dv_q;
    logic [DIG_W+1:0]    dv_r;

    function automatic logic [DIFF_W-1:0] dcomp(input node_t a, input node_t b,
                                                input logic [1:0] k);
        coord_t av, bv;
        unique case (k)
            2'd0:    begin av = a.x; bv = b.x; end
            2'd1:    begin av = a.y; bv = b.y; end
            default: begin av = a.z; bv = b.z; end
        endcase
        return {av[COORD_W-1], av} - {bv[COORD_W-1], bv};
    endfunction

    function automatic logic [CRS_W-1:0] sx(input logic [DIFF_W-1:0] v);
        return {{(CRS_W-DIFF_W){v[DIFF_W-1]}}, v};
    endfunction

    function automatic logic [CRS_W-1:0] mag(input logic [CRS_W-1:0] v);
        return v[CRS_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign cur       = part_of(job_reg.kind, part_reg);
    assign part_mask = (STORED_NODES'(1) << cur.n0) | (STORED_NODES'(1) << cur.n1)
                     | (STORED_NODES'(1) << cur.n2) | (STORED_NODES'(1) << cur.n3);
    assign dot_k     = 2'(step_reg - 4'd6);
    assign out_valid = out_valid_reg;
    assign measure   = measure_reg;
    assign status    = status_reg;

    always_comb
    begin
        unique case (ld_cnt_reg[1:0])
            2'd0:    ld_idx = cur.n0;
            2'd1:    ld_idx = cur.n1;
            2'd2:    ld_idx = cur.n2;
            default: ld_idx = cur.n3;
        endcase
        rd_addr = {job_reg.bank, ld_idx};

        if (step_reg < 4'd6)
        begin
            a_op = sx(x_reg[mul_a_idx(step_reg[2:0])]);
            b_op = sx(y_reg[mul_b_idx(step_reg[2:0])]);
        end
        else
        begin
            a_op = cur.tet ? sx(u_reg[dot_k]) : c_reg[dot_k];
            b_op = c_reg[dot_k];
        end

        mul_sum  = {1'b0, prod_reg[PROD_W-1:CRS_W]}
                 + (prod_reg[0] ? {1'b0, a_mag_reg} : '0);
        sprod    = neg_reg ? (~{2'b00, prod_reg} + 1'b1) : {2'b00, prod_reg};
        acc_abs  = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        sq_t     = {rem_reg, rad_reg[PROD_W-1:PROD_W-2]};
        sq_trial = {2'b00, root_reg, 2'b01};
        // one quotient digit: multiply by the rounded-up reciprocal of three
        dv_t     = {drem_reg, div_reg[QUO_W-1 -: DIG_W]};
        dv_prod  = {{(DIG_W+2){1'b0}}, dv_t} * {{(DIG_W+2){1'b0}}, DIV3_MUL};
        dv_q     = dv_prod[DIV3_SHIFT +: DIG_W];
        dv_r     = dv_t - {1'b0, dv_q, 1'b0} - {2'b00, dv_q};
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        part_next      = part_reg;
        ld_cnt_next    = ld_cnt_reg;
        lnode_next     = lnode_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        u_next         = u_reg;
        c_next         = c_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        a_mag_next     = a_mag_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        it_next        = it_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        area_next      = area_reg;
        vol_next       = vol_reg;
        div_next       = div_reg;
        quo_next       = quo_reg;
        drem_next      = drem_reg;
        res_meas_next  = res_meas_reg;
        res_stat_next  = res_stat_reg;
        measure_next   = measure_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        rel.valid      = 1'b0;
        rel.bank       = job_reg.bank;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    job_next  = q_job;
                    part_next = '0;
                    area_next = '0;
                    vol_next  = '0;
                    if (q_job.status != ST_OK)
                    begin
                        res_meas_next = '0;
                        res_stat_next = q_job.status;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SEL;
                    end
                end
            end
            S_SEL:
            begin
                // skip parts that touch a missing node
                if (part_reg == part_total(job_reg.kind))
                    state_next = S_FIN;
                else if ((part_mask & job_reg.present) != part_mask)
                    part_next = part_reg + 1'b1;
                else
                begin
                    ld_cnt_next = '0;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (ld_cnt_reg != 3'd0)
                begin
                    lnode_next[2'(ld_cnt_reg - 3'd1)] = rd_data;
                end
                if (ld_cnt_reg == 3'd4)
                    state_next = S_DIFF;
                else
                    ld_cnt_next = ld_cnt_reg + 1'b1;
            end
            S_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    x_next[k] = cur.tet ? dcomp(lnode_reg[2], lnode_reg[0], 2'(k))
                                        : dcomp(lnode_reg[0], lnode_reg[1], 2'(k));
                    y_next[k] = cur.tet ? dcomp(lnode_reg[3], lnode_reg[0], 2'(k))
                                        : dcomp(lnode_reg[2], lnode_reg[3], 2'(k));
                    u_next[k] = dcomp(lnode_reg[1], lnode_reg[0], 2'(k));
                    c_next[k] = '0;
                end
                acc_next   = '0;
                step_next  = '0;
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                a_mag_next = mag(a_op);
                prod_next  = {{CRS_W{1'b0}}, mag(b_op)};
                neg_next   = a_op[CRS_W-1] ^ b_op[CRS_W-1];
                it_next    = '0;
                state_next = S_MRUN;
            end
            S_MRUN:
            begin
                prod_next = {mul_sum, prod_reg[CRS_W-1:1]};
                it_next   = it_reg + 1'b1;
                if (it_reg == MUL_LAST)
                    state_next = S_MACC;
            end
            S_MACC:
            begin
                if (step_reg < 4'd6)
                begin
                    if (step_reg[0])
                        c_next[step_reg[2:1]] = c_reg[step_reg[2:1]] - sprod[CRS_W-1:0];
                    else
                        c_next[step_reg[2:1]] = c_reg[step_reg[2:1]] + sprod[CRS_W-1:0];
                end
                else
                begin
                    acc_next = acc_reg + sprod;
                end
                if (step_reg == 4'd8)
                    state_next = S_POST;
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_MSTART;
                end
            end
            S_POST:
            begin
                if (cur.tet)
                begin
                    vol_next   = vol_reg + acc_abs[VOL_W-1:0];
                    part_next  = part_reg + 1'b1;
                    state_next = S_SEL;
                end
                else
                begin
                    rad_next   = acc_reg[PROD_W-1:0];
                    rem_next   = '0;
                    root_next  = '0;
                    it_next    = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_t >= sq_trial)
                begin
                    rem_next  = REM_W'(sq_t - sq_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_t[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next = {rad_reg[PROD_W-3:0], 2'b00};
                it_next  = it_reg + 1'b1;
                if (it_reg == SQRT_LAST)
                    state_next = S_AREA;
            end
            S_AREA:
            begin
                area_next  = area_reg + {1'b0, root_reg};
                part_next  = part_reg + 1'b1;
                state_next = S_SEL;
            end
            S_FIN:
            begin
                if (job_reg.kind == KIND_TRI || job_reg.kind == KIND_QUAD)
                begin
                    res_meas_next = MEAS_W'(area_reg >> AREA_SHIFT);
                    res_stat_next = ST_OK;
                    state_next    = S_OUT;
                end
                else
                begin
                    div_next   = QUO_W'(vol_reg[VOL_W-1:VOL_SHIFT]);
                    quo_next   = '0;
                    drem_next  = '0;
                    it_next    = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // long division by three, one digit per cycle, top digit first
                drem_next = dv_r[1:0];
                quo_next  = {quo_reg[QUO_W-DIG_W-1:0], dv_q};
                div_next  = {div_reg[QUO_W-DIG_W-1:0], {DIG_W{1'b0}}};
                it_next   = it_reg + 1'b1;
                if (it_reg == DIV_LAST)
                    state_next = S_DIVDONE;
            end
            S_DIVDONE:
            begin
                if (quo_reg[QUO_W-1:MEAS_W] != '0)
                begin
                    res_meas_next = '1;
                    res_stat_next = ST_SAT;
                end
                else
                begin
                    res_meas_next = quo_reg[MEAS_W-1:0];
                    res_stat_next = ST_OK;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    measure_next   = res_meas_reg;
                    status_next    = res_stat_reg;
                    rel.valid      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        part_reg     <= part_next;
        ld_cnt_reg   <= ld_cnt_next;
        lnode_reg    <= lnode_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        u_reg        <= u_next;
        c_reg        <= c_next;
        acc_reg      <= acc_next;
        step_reg     <= step_next;
        a_mag_reg    <= a_mag_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        it_reg       <= it_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        area_reg     <= area_next;
        vol_reg      <= vol_next;
        div_reg      <= div_next;
        quo_reg      <= quo_next;
        drem_reg     <= drem_next;
        res_meas_reg <= res_meas_next;
        res_stat_reg <= res_stat_next;
        measure_reg  <= measure_next;
        status_reg   <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_SAT |-> measure_reg == '1)
        else $error("saturated result is not all ones");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_FEW || status_reg == ST_MISSING
                          || status_reg == ST_UNSUP) |-> measure_reg == '0)
        else $error("error result carries a nonzero measure");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the mesh element measure block.
`timescale 1ns / 1ps

module testbench;
    import mem_pkg::*;

    // Kind codes the package leaves out: everything above the hexahedron is unsupported.
    localparam logic [KIND_W-1:0] KIND_UNSUP = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TOP   = 3'd7;
    localparam int N_ITEMS = 400;

    typedef logic signed [255:0] swide_t;
    typedef logic [255:0]        uwide_t;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic               present;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
    } node_beat_t;

    typedef struct {
        logic [MEAS_W-1:0]   measure;
        logic [STATUS_W-1:0] status;
    } measure_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [KIND_W-1:0] element_kind;
    logic node_present;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic last_node;
    logic out_valid;
    logic out_ready;
    logic [MEAS_W-1:0] measure;
    logic [STATUS_W-1:0] status;

    node_beat_t node_queue[$];      // beats waiting to be driven
    measure_t   measure_queue[$];   // measures predicted, oldest first
    int         mismatches = 0;

    // Shadow state of the element being collected.
    logic signed [COORD_W-1:0] shadow_xyz[STORED_NODES][3];
    logic [STORED_NODES-1:0]   shadow_present;
    int                        shadow_count;
    logic [KIND_W-1:0]         shadow_kind;

    mesh_element_measure DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .element_kind(element_kind), .node_present(node_present),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .last_node(last_node),
        .out_valid(out_valid), .out_ready(out_ready),
        .measure(measure), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------- predictor
    function automatic swide_t coord_diff(int a, int b, int k);
        swide_t p;
        swide_t q;
        p = shadow_xyz[a][k];
        q = shadow_xyz[b][k];
        return p - q;
    endfunction

    function automatic uwide_t floor_sqrt(uwide_t n);
        uwide_t r;
        uwide_t c;
        r = '0;
        for (int i = 127; i >= 0; i--)
        begin
            c = r;
            c[i] = 1'b1;
            if (c * c <= n)
                r = c;
        end
        return r;
    endfunction

    // floor of |(p-q) x (r-s)|, 32 fraction bits
    function automatic uwide_t cross_length(int p, int q, int r, int s);
        swide_t a[3];
        swide_t b[3];
        swide_t c0, c1, c2;
        for (int k = 0; k < 3; k++)
        begin
            a[k] = coord_diff(p, q, k);
            b[k] = coord_diff(r, s, k);
        end
        c0 = a[1] * b[2] - a[2] * b[1];
        c1 = a[2] * b[0] - a[0] * b[2];
        c2 = a[0] * b[1] - a[1] * b[0];
        return floor_sqrt(uwide_t'(c0 * c0 + c1 * c1 + c2 * c2));
    endfunction

    // |triple product| of one tetrahedron, 48 fraction bits
    function automatic uwide_t tet_product(int n0, int n1, int n2, int n3);
        swide_t v1[3];
        swide_t v2[3];
        swide_t v3[3];
        swide_t t;
        for (int k = 0; k < 3; k++)
        begin
            v1[k] = coord_diff(n1, n0, k);
            v2[k] = coord_diff(n2, n0, k);
            v3[k] = coord_diff(n3, n0, k);
        end
        t = v1[0] * (v2[1] * v3[2] - v2[2] * v3[1])
          + v1[1] * (v2[2] * v3[0] - v2[0] * v3[2])
          + v1[2] * (v2[0] * v3[1] - v2[1] * v3[0]);
        return (t < 0) ? uwide_t'(-t) : uwide_t'(t);
    endfunction

    // Fold one accepted node into the shadow state; close the element on its last node.
    function automatic void track_node(node_beat_t nb);
        int hex_sets[6][4] = '{'{0, 1, 3, 4}, '{1, 2, 3, 6}, '{1, 3, 4, 6},
                               '{3, 4, 6, 7}, '{1, 4, 5, 6}, '{4, 6, 7, 5}};
        int need;
        logic [STORED_NODES-1:0] used;
        uwide_t m;
        measure_t res;
        if (shadow_count == 0)
            shadow_kind = nb.kind;
        if (shadow_count < STORED_NODES)
        begin
            shadow_xyz[shadow_count][0] = nb.x;
            shadow_xyz[shadow_count][1] = nb.y;
            shadow_xyz[shadow_count][2] = nb.z;
            if (nb.present)
                shadow_present[shadow_count] = 1'b1;
        end
        if (shadow_count < MAX_ELEMENT_NODES)
            shadow_count++;
        if (!nb.last)
            return;

        m = '0;
        res.status = ST_OK;
        need = (shadow_kind == KIND_TRI) ? 3 : (shadow_kind == KIND_HEX) ? 8 : 4;
        used = STORED_NODES'((1 << need) - 1);
        if (shadow_kind > KIND_HEX)
            res.status = ST_UNSUP;
        else if (shadow_count < need)
            res.status = ST_FEW;
        else if (shadow_kind != KIND_HEX && (shadow_present & used) != used)
            res.status = ST_MISSING;
        else if (shadow_kind == KIND_TRI)
            m = cross_length(1, 0, 2, 0) >> AREA_SHIFT;
        else if (shadow_kind == KIND_QUAD)
            m = (cross_length(1, 0, 3, 0) + cross_length(2, 1, 2, 3)) >> AREA_SHIFT;
        else if (shadow_kind == KIND_TET)
            m = (tet_product(0, 1, 2, 3) >> 24) / 6;
        else
        begin
            // skip every tetrahedron that touches a missing node
            for (int t = 0; t < 6; t++)
            begin
                used = '0;
                for (int k = 0; k < 4; k++)
                    used[hex_sets[t][k]] = 1'b1;
                if ((shadow_present & used) == used)
                    m += tet_product(hex_sets[t][0], hex_sets[t][1],
                                     hex_sets[t][2], hex_sets[t][3]);
            end
            m = (m >> 24) / 6;
        end
        if (m[255:MEAS_W] != '0)
        begin
            res.measure = '1;
            res.status = ST_SAT;
        end
        else
            res.measure = m[MEAS_W-1:0];
        measure_queue.push_back(res);
        shadow_count = 0;
        shadow_present = '0;
        shadow_kind = '0;
    endfunction

    // ---------------------------------------------------------------- stimulus
    function automatic logic [COORD_W-1:0] pick_coord(int spread);
        logic [COORD_W-1:0] ends[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        case (spread)
            0:       return COORD_W'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
            1:       return $urandom;
            default: return ends[$urandom_range(0, 3)];
        endcase
    endfunction

    // Queue one element; miss_pct is the chance in percent that a node is missing.
    task automatic add_element(logic [KIND_W-1:0] kind, int nodes, int miss_pct, int spread);
        node_beat_t nb;
        for (int i = 0; i < nodes; i++)
        begin
            // only the first node's kind counts; later ones carry noise
            nb.kind = (i == 0) ? kind : KIND_W'($urandom_range(0, KIND_TOP));
            nb.present = ($urandom_range(0, 99) >= miss_pct);
            nb.x = pick_coord(spread);
            nb.y = pick_coord(spread);
            nb.z = pick_coord(spread);
            nb.last = (i == nodes - 1);
            node_queue.push_back(nb);
        end
    endtask

    initial
    begin
        logic [KIND_W-1:0] kind;
        int need;
        int nodes;
        int r;
        // directed: each kind once, too few nodes, missing node, unsupported, saturation
        add_element(KIND_TRI, 3, 0, 0);
        add_element(KIND_TRI, 2, 0, 1);
        add_element(KIND_TET, 4, 50, 0);
        add_element(KIND_TOP, 1, 0, 2);
        add_element(KIND_QUAD, 4, 0, 1);
        add_element(KIND_HEX, 8, 0, 2);
        // random: mostly well-formed elements, some short, long, broken or unsupported
        while (node_queue.size() < N_ITEMS)
        begin
            r = $urandom_range(0, 99);
            kind = (r < 8) ? KIND_W'($urandom_range(KIND_UNSUP, KIND_TOP))
                           : KIND_W'($urandom_range(KIND_TRI, KIND_HEX));
            need = (kind == KIND_TRI) ? 3 : (kind == KIND_HEX) ? 8 : 4;
            r = $urandom_range(0, 99);
            if (r < 70)
                nodes = need;
            else if (r < 85)
                nodes = $urandom_range(1, need - 1);
            else
                nodes = $urandom_range(need + 1, MAX_ELEMENT_NODES + 5);
            r = $urandom_range(0, 99);
            add_element(kind, nodes, (r < 75) ? 0 : 30,
                        (r % 10 < 6) ? 0 : (r % 10 < 9) ? 1 : 2);
        end
    end

    // Random idle length: mostly none or short, a few long, with calm stretches.
    function automatic int pick_gap(inout logic calm);
        int r;
        if ($urandom_range(0, 31) == 0)
            calm = ~calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------- driver
    int         send_gap;
    logic       send_calm;
    node_beat_t send_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            element_kind <= '0;
            node_present <= 1'b0;
            coord_x <= '0;
            coord_y <= '0;
            coord_z <= '0;
            last_node <= 1'b0;
            send_gap = 0;
            send_calm = 1'b0;
            shadow_count = 0;
            shadow_present = '0;
            shadow_kind = '0;
        end
        else
        begin
            // predict on the beat the block takes at this edge
            if (in_valid && in_ready)
                track_node(send_beat);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (node_queue.size() > 0)
                begin
                    send_beat = node_queue.pop_front();
                    element_kind <= send_beat.kind;
                    node_present <= send_beat.present;
                    coord_x <= send_beat.x;
                    coord_y <= send_beat.y;
                    coord_z <= send_beat.z;
                    last_node <= send_beat.last;
                    in_valid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    int   recv_stall;
    logic recv_calm;

    always @(posedge clk or negedge rst_n)
    begin
        measure_t exp_res;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
            recv_calm = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (measure_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: measure %h status %0d", measure, status);
                end
                else
                begin
                    exp_res = measure_queue.pop_front();
                    if (measure !== exp_res.measure || status !== exp_res.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: measure %h status %0d, expected %h status %0d",
                                     measure, status, exp_res.measure, exp_res.status);
                    end
                end
            end
            // hold ready low for the chosen stall, then raise it and pick the next stall
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall = pick_gap(recv_calm);
            end
        end
    end

    // ---------------------------------------------------------------- end of run
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (node_queue.size() > 0 || in_valid)
            @(posedge clk);
        while (measure_queue.size() > 0)
            @(posedge clk);
        // let any stray result show up
        repeat (200) @(posedge clk);
        if (mismatches == 0 && measure_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Allow many times the slowest run, hexahedra being the slowest elements.
    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> mesh_element_measure.f
hdl/mem_pkg.sv
hdl/mem_front.sv
hdl/mem_queue.sv
hdl/mem_back.sv
hdl/mesh_element_measure.sv
dv/testbench.sv
